/* hw/rtl/debounced_button_mode_controller_defines.svh */
// Assertion macros for the debounced button mode controller.
`ifndef DEBOUNCED_BUTTON_MODE_CONTROLLER_DEFINES_SVH
`define DEBOUNCED_BUTTON_MODE_CONTROLLER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define DBMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge, reset included.
`define DBMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/dbmc_pkg.sv */
// Types and constants shared by the debounced button mode controller.
package dbmc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_STOP = 2'd2,
    ST_ERR  = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    MD_NONE = 2'd0,
    MD_OBST = 2'd1,
    MD_WALL = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    LED_OFF   = 3'd0,
    LED_SOLID = 3'd1,
    LED_SLOW  = 3'd2,
    LED_FAST  = 3'd3,
    LED_ONCE  = 3'd4,
    LED_TWICE = 3'd5
  } led_t;

  typedef enum logic [2:0] {
    KIND_PRESS     = 3'd0,
    KIND_UPDATE    = 3'd1,
    KIND_SET_STATE = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    BUTTON_GREEN = 2'd0,
    BUTTON_RED   = 2'd1,
    BUTTON_BLUE  = 2'd2,
    BUTTON_WHITE = 2'd3
  } button_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_SHORT    = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_reg_t;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd200;
  localparam logic [CFG_W-1:0] SHORT_RST    = 16'd500;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

  // Control from the event stage to the button tracker.
  typedef struct packed {
    logic              press;
    logic              clear;
    logic [1:0]        id;
    logic [TIME_W-1:0] now;
    logic [CFG_W-1:0]  debounce;
  } btn_ctl_t;

endpackage

/* hw/rtl/debounced_button_mode_controller.sv */
// Top level of the debounced button mode controller.
// Each input transaction is one event and returns exactly one result transaction
// showing the state after that event. An event is registered at the input, processed
// from that register once the output register can take it, and written to the output
// register; one event is taken every cycle while the output is not stalled, and the
// rate is set by the single event stage that updates the run state and button flags.
// Presses are filtered per button by a wrapping 32-bit millisecond compare against
// debounce_ms. Configuration writes are to be made only while no event is in flight.
`include "debounced_button_mode_controller_defines.svh"

module debounced_button_mode_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [1:0]  button_id,
  input  logic [31:0] now_ms,
  input  logic [1:0]  new_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  car_state,
  output logic [1:0]  car_mode,
  output logic [15:0] target_mm,
  output logic [2:0]  led_pattern,
  output logic        start_pulse,
  output logic        stop_pulse,
  output logic        mode_changed
);
  import dbmc_pkg::*;

  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] short_distance_mm;
  logic [CFG_W-1:0] long_distance_mm;

  logic              s1_valid;
  logic [2:0]        s1_kind;
  logic [1:0]        s1_id;
  logic [TIME_W-1:0] s1_now;
  logic [1:0]        s1_new_state;

  state_t           run_state, run_state_next;
  mode_t            mode_reg, mode_reg_next;
  logic             distance_long, distance_long_next;
  logic [CFG_W-1:0] target_reg, target_reg_next;
  led_t             led_reg, led_reg_next;
  logic             start_next, stop_next, mode_next;

  logic                   adv;
  logic                   in_accept;
  btn_ctl_t               btn_ctl;
  logic [NUM_BUTTONS-1:0] pending;

  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= DEBOUNCE_RST;
      short_distance_mm <= SHORT_RST;
      long_distance_mm  <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_ms       <= cfg_data;
        CFG_SHORT:    short_distance_mm <= cfg_data;
        CFG_LONG:     long_distance_mm  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind      <= kind;
      s1_id        <= button_id;
      s1_now       <= now_ms;
      s1_new_state <= new_state;
    end
  end

  always_comb begin
    btn_ctl.press    = adv && (s1_kind == KIND_PRESS);
    btn_ctl.clear    = adv && (s1_kind == KIND_UPDATE);
    btn_ctl.id       = s1_id;
    btn_ctl.now      = s1_now;
    btn_ctl.debounce = debounce_ms;
  end

  dbmc_buttons u_buttons (
    .clk     (clk),
    .rst     (rst),
    .ctl     (btn_ctl),
    .pending (pending)
  );

  // Event processing; update handles green, red, blue, white in that order
  always_comb begin
    run_state_next     = run_state;
    mode_reg_next      = mode_reg;
    distance_long_next = distance_long;
    target_reg_next    = target_reg;
    led_reg_next       = led_reg;
    start_next         = 1'b0;
    stop_next          = 1'b0;
    mode_next          = 1'b0;
    case (s1_kind)
      KIND_UPDATE: begin
        if (pending[BUTTON_GREEN]) begin
          if ((run_state_next inside {ST_IDLE, ST_STOP}) && mode_reg_next != MD_NONE) begin
            run_state_next = ST_RUN;
            led_reg_next   = LED_FAST;
            start_next     = 1'b1;
          end
        end
        if (pending[BUTTON_RED]) begin
          if (run_state_next == ST_RUN) begin
            run_state_next = ST_STOP;
            led_reg_next   = LED_OFF;
            stop_next      = 1'b1;
          end else if (run_state_next == ST_STOP) begin
            run_state_next  = ST_IDLE;
            mode_reg_next   = MD_NONE;
            target_reg_next = '0;
            led_reg_next    = LED_SLOW;
            mode_next       = 1'b1;
          end
        end
        if (pending[BUTTON_BLUE] && (run_state_next inside {ST_IDLE, ST_STOP})) begin
          if (mode_reg_next == MD_OBST && !distance_long_next) begin
            distance_long_next = 1'b1;
            target_reg_next    = long_distance_mm;
            led_reg_next       = LED_TWICE;
          end else begin
            mode_reg_next      = MD_OBST;
            distance_long_next = 1'b0;
            target_reg_next    = short_distance_mm;
            led_reg_next       = LED_ONCE;
          end
          mode_next = 1'b1;
        end
        if (pending[BUTTON_WHITE] && (run_state_next inside {ST_IDLE, ST_STOP})) begin
          mode_reg_next   = MD_WALL;
          target_reg_next = '0;
          led_reg_next    = LED_SOLID;
          mode_next       = 1'b1;
        end
      end
      KIND_SET_STATE: begin
        run_state_next = state_t'(s1_new_state);
        case (state_t'(s1_new_state))
          ST_IDLE: led_reg_next = LED_SLOW;
          ST_STOP: led_reg_next = LED_OFF;
          default: led_reg_next = LED_FAST;
        endcase
      end
      KIND_DONE: begin
        run_state_next = ST_STOP;
        led_reg_next   = LED_SOLID;
      end
      KIND_ERROR: begin
        run_state_next = ST_ERR;
        led_reg_next   = LED_FAST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state     <= ST_IDLE;
      mode_reg      <= MD_NONE;
      distance_long <= 1'b0;
      target_reg    <= '0;
      led_reg       <= LED_SLOW;
    end else if (adv) begin
      run_state     <= run_state_next;
      mode_reg      <= mode_reg_next;
      distance_long <= distance_long_next;
      target_reg    <= target_reg_next;
      led_reg       <= led_reg_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      car_state    <= run_state_next;
      car_mode     <= mode_reg_next;
      target_mm    <= target_reg_next;
      led_pattern  <= led_reg_next;
      start_pulse  <= start_next;
      stop_pulse   <= stop_next;
      mode_changed <= mode_next;
    end
  end

  `DBMC_ASSERT(a_start_state,
    (out_valid && start_pulse) |-> (car_state == ST_RUN || car_state == ST_STOP),
    "start reported without a running or stopped car")
  `DBMC_ASSERT(a_target_mode,
    (out_valid && target_mm != '0) |-> (car_mode == MD_OBST),
    "nonzero target outside obstacle mode")
  `DBMC_ASSERT(a_clear_mode,
    (out_valid && mode_changed && car_mode == MD_NONE) |->
      (car_state == ST_IDLE && target_mm == '0),
    "mode cleared without return to idle")
  `DBMC_ASSERT_ALWAYS(a_stall_busy,
    in_stall |-> s1_valid,
    "input stalled with empty event stage")

endmodule

/* hw/rtl/dbmc_buttons.sv */
// Per-button debounce timestamps and pending flags.
module dbmc_buttons (
  input  logic                             clk,
  input  logic                             rst,
  input  dbmc_pkg::btn_ctl_t               ctl,
  output logic [dbmc_pkg::NUM_BUTTONS-1:0] pending
);
  import dbmc_pkg::*;

  logic [TIME_W-1:0] last_press [NUM_BUTTONS];
  logic [TIME_W-1:0] elapsed;
  logic              pass;

  assign elapsed = ctl.now - last_press[ctl.id];
  assign pass    = elapsed >= {{(TIME_W-CFG_W){1'b0}}, ctl.debounce};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        last_press[i] <= '0;
      end
    end else if (ctl.clear) begin
      pending <= '0;
    end else if (ctl.press && pass) begin
      pending[ctl.id]    <= 1'b1;
      last_press[ctl.id] <= ctl.now;
    end
  end

endmodule

/* bench/tb_debounced_button_mode_controller.sv */
// Self-checking bench for the button mode controller: predicted vs. observed status per event.
`timescale 1ns / 1ps

module tb_debounced_button_mode_controller;
  import dbmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 4;
  localparam int KIND_CODES     = 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  button_id;
    logic [31:0] now_ms;
    logic [1:0]  new_state;
  } panel_event_t;

  typedef struct packed {
    logic [1:0]  car_state;
    logic [1:0]  car_mode;
    logic [15:0] target_mm;
    logic [2:0]  led_pattern;
    logic        start_pulse;
    logic        stop_pulse;
    logic        mode_changed;
  } panel_status_t;

  class panel_status_tracker;
    logic [15:0] debounce_ms, short_mm, long_mm;
    logic [1:0] run_state, mode;
    logic dist_long;
    logic [15:0] target;
    logic [2:0] led;
    logic [31:0] last_press [NUM_BUTTONS];
    bit pending [NUM_BUTTONS];
    panel_status_t expected_status_q [$];
    int mismatches;

    function new();
      debounce_ms = DEBOUNCE_RST;
      short_mm = SHORT_RST;
      long_mm = LONG_RST;
      run_state = ST_IDLE;
      mode = MD_NONE;
      dist_long = 1'b0;
      target = '0;
      led = LED_SLOW;
      foreach (last_press[i]) begin
        last_press[i] = '0;
        pending[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_DEBOUNCE: debounce_ms = val;
        CFG_SHORT:    short_mm = val;
        CFG_LONG:     long_mm = val;
        default: ;
      endcase
    endfunction

    function bit may_select();
      return run_state == ST_IDLE || run_state == ST_STOP;
    endfunction

    function void note_event(panel_event_t ev);
      panel_status_t s;
      logic [31:0] elapsed;
      s.start_pulse = 1'b0;
      s.stop_pulse = 1'b0;
      s.mode_changed = 1'b0;
      case (ev.kind)
        KIND_PRESS: begin
          elapsed = ev.now_ms - last_press[ev.button_id];
          if (elapsed >= {16'd0, debounce_ms}) begin
            last_press[ev.button_id] = ev.now_ms;
            pending[ev.button_id] = 1'b1;
          end
        end
        KIND_UPDATE: begin
          if (pending[BUTTON_GREEN]) begin
            pending[BUTTON_GREEN] = 1'b0;
            if (may_select() && mode != MD_NONE) begin
              run_state = ST_RUN;
              led = LED_FAST;
              s.start_pulse = 1'b1;
            end
          end
          if (pending[BUTTON_RED]) begin
            pending[BUTTON_RED] = 1'b0;
            if (run_state == ST_RUN) begin
              run_state = ST_STOP;
              led = LED_OFF;
              s.stop_pulse = 1'b1;
            end else if (run_state == ST_STOP) begin
              run_state = ST_IDLE;
              mode = MD_NONE;
              target = '0;
              led = LED_SLOW;
              s.mode_changed = 1'b1;
            end
          end
          if (pending[BUTTON_BLUE]) begin
            pending[BUTTON_BLUE] = 1'b0;
            if (may_select()) begin
              if (mode == MD_OBST && !dist_long) begin
                dist_long = 1'b1;
                target = long_mm;
                led = LED_TWICE;
              end else begin
                mode = MD_OBST;
                dist_long = 1'b0;
                target = short_mm;
                led = LED_ONCE;
              end
              s.mode_changed = 1'b1;
            end
          end
          if (pending[BUTTON_WHITE]) begin
            pending[BUTTON_WHITE] = 1'b0;
            if (may_select()) begin
              mode = MD_WALL;
              target = '0;
              led = LED_SOLID;
              s.mode_changed = 1'b1;
            end
          end
        end
        KIND_SET_STATE: begin
          run_state = ev.new_state;
          if (ev.new_state == ST_IDLE) led = LED_SLOW;
          else if (ev.new_state == ST_STOP) led = LED_OFF;
          else led = LED_FAST;
        end
        KIND_DONE: begin
          run_state = ST_STOP;
          led = LED_SOLID;
        end
        KIND_ERROR: begin
          run_state = ST_ERR;
          led = LED_FAST;
        end
        default: ;
      endcase
      s.car_state = run_state;
      s.car_mode = mode;
      s.target_mm = target;
      s.led_pattern = led;
      expected_status_q.push_back(s);
    endfunction

    function void report_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: %s expected %0d got %0d", what, exp_v, got_v);
    endfunction

    function void check_status(panel_status_t got);
      panel_status_t exp_s;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status transaction with none pending, state %0d", got.car_state);
        return;
      end
      exp_s = expected_status_q.pop_front();
      if (got.car_state !== exp_s.car_state)
        report_field("car_state", 32'(exp_s.car_state), 32'(got.car_state));
      if (got.car_mode !== exp_s.car_mode)
        report_field("car_mode", 32'(exp_s.car_mode), 32'(got.car_mode));
      if (got.target_mm !== exp_s.target_mm)
        report_field("target_mm", 32'(exp_s.target_mm), 32'(got.target_mm));
      if (got.led_pattern !== exp_s.led_pattern)
        report_field("led_pattern", 32'(exp_s.led_pattern), 32'(got.led_pattern));
      if (got.start_pulse !== exp_s.start_pulse)
        report_field("start_pulse", 32'(exp_s.start_pulse), 32'(got.start_pulse));
      if (got.stop_pulse !== exp_s.stop_pulse)
        report_field("stop_pulse", 32'(exp_s.stop_pulse), 32'(got.stop_pulse));
      if (got.mode_changed !== exp_s.mode_changed)
        report_field("mode_changed", 32'(exp_s.mode_changed), 32'(got.mode_changed));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [1:0]  button_id;
  logic [31:0] now_ms;
  logic [1:0]  new_state;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  car_state;
  logic [1:0]  car_mode;
  logic [15:0] target_mm;
  logic [2:0]  led_pattern;
  logic        start_pulse;
  logic        stop_pulse;
  logic        mode_changed;

  panel_status_tracker sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int idle_cycles;
  logic [31:0] clock_ms;

  debounced_button_mode_controller i_dut (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_event(input logic [2:0] k, input logic [1:0] id,
                            input logic [31:0] t, input logic [1:0] ns);
    panel_event_t ev;
    ev = '{k, id, t, ns};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    button_id <= id;
    now_ms <= t;
    new_state <= ns;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_event(ev);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] d, input logic [15:0] s, input logic [15:0] l);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(CFG_DEBOUNCE, d);
    cfg_index <= CFG_SHORT;
    cfg_data <= s;
    @(posedge clk);
    sb.set_reg(CFG_SHORT, s);
    cfg_index <= CFG_LONG;
    cfg_data <= l;
    @(posedge clk);
    sb.set_reg(CFG_LONG, l);
    cfg_index <= CFG_UNUSED;
    cfg_data <= junk;
    @(posedge clk);
    sb.set_reg(CFG_UNUSED, junk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [15:0] d,
                           input logic [15:0] s, input logic [15:0] l, input int count,
                           input bit hold);
    int r;
    logic [2:0] k;
    logic [31:0] t;
    drain_results();
    write_regs(d, s, l);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_req = 1'b1;
    clock_ms = $urandom;
    repeat (count) begin
      r = $urandom_range(99);
      t = $urandom;
      if (r < 45) begin
        k = KIND_PRESS;
        // mostly a running clock so that presses land on both sides of the window
        if ($urandom_range(9) != 0) begin
          clock_ms = clock_ms + $urandom_range(0, 2 * int'(d) + 2);
          t = clock_ms;
        end
      end else if (r < 80) k = KIND_UPDATE;
      else if (r < 88) k = KIND_SET_STATE;
      else if (r < 92) k = KIND_DONE;
      else if (r < 95) k = KIND_ERROR;
      else k = 3'($urandom_range(KIND_ERROR + 1, KIND_CODES - 1));
      send_event(k, 2'($urandom_range(3)), t, 2'($urandom_range(3)));
    end
  endtask

  // result side
  initial begin
    panel_status_t got;
    hold_req = 1'b0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{car_state, car_mode, target_mm, led_pattern,
                start_pulse, stop_pulse, mode_changed};
        sb.check_status(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("debounced_button_mode_controller: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    kind <= KIND_PRESS;
    button_id <= BUTTON_GREEN;
    now_ms <= '0;
    new_state <= ST_IDLE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed events at reset configuration
    send_event(KIND_UPDATE, BUTTON_GREEN, 32'd0, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_GREEN, 32'd100, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_GREEN, 32'd200, ST_IDLE);
    send_event(KIND_UPDATE, BUTTON_GREEN, 32'd0, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_BLUE, 32'd1000, ST_IDLE);
    send_event(KIND_UPDATE, BUTTON_BLUE, 32'd0, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_BLUE, 32'd1200, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_BLUE, 32'd1399, ST_IDLE);
    send_event(KIND_UPDATE, BUTTON_BLUE, 32'd0, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_GREEN, 32'd2000, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_RED, 32'd2000, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_BLUE, 32'd2000, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_WHITE, 32'd2000, ST_IDLE);
    send_event(KIND_UPDATE, BUTTON_WHITE, 32'hFFFF_FFFF, ST_ERR);
    send_event(KIND_PRESS, BUTTON_RED, 32'd3000, ST_IDLE);
    send_event(KIND_UPDATE, BUTTON_RED, 32'd0, ST_IDLE);
    // timestamp wrap
    send_event(KIND_PRESS, BUTTON_WHITE, 32'hFFFF_FFFF, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_WHITE, 32'h0000_00C7, ST_IDLE);
    send_event(KIND_PRESS, BUTTON_WHITE, 32'h0000_0100, ST_IDLE);
    send_event(KIND_UPDATE, BUTTON_WHITE, 32'd0, ST_IDLE);
    for (int k = KIND_ERROR + 1; k < KIND_CODES; k++)
      send_event(3'(k), BUTTON_WHITE, 32'hFFFF_FFFF, ST_ERR);
    send_event(KIND_SET_STATE, BUTTON_GREEN, 32'd0, ST_IDLE);
    send_event(KIND_SET_STATE, BUTTON_GREEN, 32'd0, ST_RUN);
    send_event(KIND_SET_STATE, BUTTON_GREEN, 32'd0, ST_STOP);
    send_event(KIND_SET_STATE, BUTTON_GREEN, 32'd0, ST_ERR);
    send_event(KIND_DONE, BUTTON_RED, 32'd0, ST_RUN);
    send_event(KIND_ERROR, BUTTON_BLUE, 32'd0, ST_IDLE);

    run_phase(0, 0, 16'd0, 16'd1, 16'hFFFF, 200, 1'b0);
    run_phase(60, 0, 16'hFFFF, 16'hFFFF, 16'd0, 200, 1'b0);
    run_phase(0, 60, 16'($urandom_range(1, 400)), 16'($urandom), 16'($urandom), 200, 1'b0);
    run_phase(17, 17, DEBOUNCE_RST, SHORT_RST, LONG_RST, 200, 1'b0);
    run_phase(0, 0, 16'd50, 16'($urandom), 16'($urandom), 200, 1'b1);
    drain_results();

    if (sb.mismatches == 0 && sb.expected_status_q.size() == 0)
      $display("debounced_button_mode_controller: match");
    else
      $display("debounced_button_mode_controller: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dbmc_pkg.sv
hw/rtl/dbmc_buttons.sv
hw/rtl/debounced_button_mode_controller.sv
bench/tb_debounced_button_mode_controller.sv
